@@ src/mlpq_pkg.sv @@
`default_nettype none

package mlpq_pkg;

    // queue geometry
    localparam int LEVELS      = 4;
    localparam int LEVEL_DEPTH = 16;
    localparam int ID_WIDTH    = 8;

    localparam int LVL_W  = $clog2(LEVELS);
    localparam int PTR_W  = $clog2(LEVEL_DEPTH);
    localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int ADDR_W = LVL_W + PTR_W;
    localparam int SLOTS  = LEVELS * (2 ** PTR_W);

    // field widths fixed by the interface
    localparam int PID_W   = 8;
    localparam int PRIO_W  = 8;
    localparam int LEVEL_W = 2;

    localparam logic [PID_W-1:0] ID_MASK =
        PID_W'((17'd1 << ID_WIDTH) - 17'd1);
    localparam logic signed [PRIO_W-1:0] PRIO_MAX = PRIO_W'(LEVELS - 1);

    typedef enum logic
    {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } opcode_t;

    typedef struct packed
    {
        opcode_t                   opcode;
        logic [PID_W-1:0]          process_id;
        logic signed [PRIO_W-1:0]  priority_req;
    } in_item_t;

    typedef struct packed
    {
        logic                taken_valid;
        logic [PID_W-1:0]    taken_id;
        logic [LEVEL_W-1:0]  taken_level;
        logic                all_empty;
        logic                dropped_full;
    } out_item_t;

    // slot RAM access from the queue control
    typedef struct packed
    {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [PID_W-1:0]   wdata;
        logic               re;
        logic [ADDR_W-1:0]  raddr;
    } mem_req_t;

    // per-operation status from the queue control
    typedef struct packed
    {
        logic                taken_valid;
        logic [LEVEL_W-1:0]  taken_level;
        logic                all_empty;
        logic                dropped_full;
    } ctrl_res_t;

endpackage

`default_nettype wire

@@ src/multilevel_priority_fifo_core.sv @@
`default_nettype none

// Four-level priority ready queue of process ids. Each transfer on the input
// channel is an enqueue (id and signed priority, out-of-range priorities go
// to level 3, id 0 is ignored) or a dequeue of the oldest id from the
// highest non-empty level, level 0 first. Every operation yields exactly one
// result, presented at the clock edge after the input register hands it on,
// and one operation is taken every clock cycle while the output is not
// stalled. The result passes through the input register and the result
// register; the slot RAM does one write or one registered read per cycle,
// with the read data landing together with the result register. Each level
// holds 16 ids; an enqueue into a full level is dropped and flagged.

module multilevel_priority_fifo_core
    import mlpq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire in_item_t   in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output out_item_t       out_data
);

    logic       in_valid_reg;
    in_item_t   in_item_reg;
    logic       out_valid_reg;
    ctrl_res_t  out_res_reg;
    logic       fire;
    mem_req_t   mem_req;
    ctrl_res_t  res;
    logic [PID_W-1:0] rd_data;

    // operation runs when the result register is free or being drained
    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
    end

    mlpq_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (in_item_reg),
        .mem_req (mem_req),
        .res     (res)
    );

    mlpq_store u_store
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_res_reg <= res;
        end
    end

    // output assembly, id comes straight from the RAM read register
    always_comb
    begin
        out_valid             = out_valid_reg;
        out_data.taken_valid  = out_res_reg.taken_valid;
        out_data.taken_id     = out_res_reg.taken_valid ? rd_data : '0;
        out_data.taken_level  = out_res_reg.taken_level;
        out_data.all_empty    = out_res_reg.all_empty;
        out_data.dropped_full = out_res_reg.dropped_full;
    end

endmodule

`default_nettype wire

@@ src/mlpq_store.sv @@
`default_nettype none

module mlpq_store
    import mlpq_pkg::*;
(
    input  wire logic             clk,
    input  wire mem_req_t         req,
    output logic [PID_W-1:0]      rd_data
);

    logic [PID_W-1:0] mem [SLOTS];

    // slot write
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // registered read, held between dequeues
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_data <= mem[req.raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/mlpq_ctrl.sv @@
`default_nettype none

module mlpq_ctrl
    import mlpq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      fire,
    input  wire in_item_t  item,
    output mem_req_t       mem_req,
    output ctrl_res_t      res
);

    logic [PTR_W-1:0] rp_reg  [LEVELS];
    logic [PTR_W-1:0] rp_next [LEVELS];
    logic [PTR_W-1:0] wp_reg  [LEVELS];
    logic [PTR_W-1:0] wp_next [LEVELS];
    logic [CNT_W-1:0] cnt_reg  [LEVELS];
    logic [CNT_W-1:0] cnt_next [LEVELS];

    logic [LEVELS-1:0] nonempty;
    logic [LVL_W-1:0]  deq_lvl;
    logic [LVL_W-1:0]  enq_lvl;
    logic [PID_W-1:0]  id;
    logic              any_empty_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // level select for enqueue: out of range goes to the lowest level
    always_comb
    begin
        id = item.process_id & ID_MASK;
        if (item.priority_req < 0 || item.priority_req > PRIO_MAX)
        begin
            enq_lvl = LVL_W'(LEVELS - 1);
        end
        else
        begin
            enq_lvl = item.priority_req[LVL_W-1:0];
        end
    end

    // priority encode of non-empty levels, level 0 wins
    always_comb
    begin
        deq_lvl = '0;
        for (int l = 0; l < LEVELS; l++)
        begin
            nonempty[l] = (cnt_reg[l] != '0);
        end
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            if (nonempty[l])
            begin
                deq_lvl = LVL_W'(l);
            end
        end
    end

    // pointer and count update, RAM request
    always_comb
    begin
        rp_next  = rp_reg;
        wp_next  = wp_reg;
        cnt_next = cnt_reg;
        mem_req  = '0;
        res      = '0;
        mem_req.wdata = id;
        if (fire)
        begin
            case (item.opcode)
                OP_ENQUEUE:
                begin
                    if (id != '0)
                    begin
                        if (cnt_reg[enq_lvl] == CNT_W'(LEVEL_DEPTH))
                        begin
                            res.dropped_full = 1'b1;
                        end
                        else
                        begin
                            mem_req.we        = 1'b1;
                            mem_req.waddr     = {enq_lvl, wp_reg[enq_lvl]};
                            wp_next[enq_lvl]  = bump(wp_reg[enq_lvl]);
                            cnt_next[enq_lvl] = cnt_reg[enq_lvl] + CNT_W'(1);
                        end
                    end
                end
                OP_DEQUEUE:
                begin
                    if (|nonempty)
                    begin
                        mem_req.re        = 1'b1;
                        mem_req.raddr     = {deq_lvl, rp_reg[deq_lvl]};
                        rp_next[deq_lvl]  = bump(rp_reg[deq_lvl]);
                        cnt_next[deq_lvl] = cnt_reg[deq_lvl] - CNT_W'(1);
                        res.taken_valid   = 1'b1;
                        res.taken_level   = LEVEL_W'(deq_lvl);
                    end
                end
                default:
                begin
                end
            endcase
        end
        // emptiness after this operation
        any_empty_next = 1'b1;
        for (int l = 0; l < LEVELS; l++)
        begin
            if (cnt_next[l] != '0)
            begin
                any_empty_next = 1'b0;
            end
        end
        res.all_empty = any_empty_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                rp_reg[l]  <= '0;
                wp_reg[l]  <= '0;
                cnt_reg[l] <= '0;
            end
        end
        else
        begin
            rp_reg  <= rp_next;
            wp_reg  <= wp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ test/multilevel_priority_fifo_core_test.sv @@
module multilevel_priority_fifo_core_test
    import mlpq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 600;
    localparam int DRAIN_CYCLES = 8;

    // shadow ready queue: predicts one result per accepted transfer
    class ready_queue_scoreboard;
        logic [PID_W-1:0] slot_ids [LEVELS][LEVEL_DEPTH];
        int               head_ptr [LEVELS];
        int               tail_ptr [LEVELS];
        int               level_fill [LEVELS];
        out_item_t        expected_results [$];
        int               errors;

        function new();
            for (int l = 0; l < LEVELS; l++)
            begin
                head_ptr[l]   = 0;
                tail_ptr[l]   = 0;
                level_fill[l] = 0;
            end
            errors = 0;
        endfunction

        // model one operation and queue its result
        function void predict_result(in_item_t item);
            out_item_t        res;
            logic [PID_W-1:0] pid;
            int               lvl;
            bit               empty;

            res = '0;
            pid = item.process_id & ID_MASK;
            if (item.opcode == OP_ENQUEUE)
            begin
                if (pid != '0)
                begin
                    // out-of-range priority lands on the lowest level
                    if (item.priority_req < 0 || item.priority_req > PRIO_MAX)
                        lvl = LEVELS - 1;
                    else
                        lvl = int'(item.priority_req);
                    if (level_fill[lvl] >= LEVEL_DEPTH)
                        res.dropped_full = 1'b1;
                    else
                    begin
                        slot_ids[lvl][tail_ptr[lvl]] = pid;
                        tail_ptr[lvl] = (tail_ptr[lvl] + 1) % LEVEL_DEPTH;
                        level_fill[lvl]++;
                    end
                end
            end
            else
            begin
                // highest non-empty level wins, oldest id first
                for (int l = 0; l < LEVELS; l++)
                begin
                    if (level_fill[l] != 0)
                    begin
                        res.taken_valid = 1'b1;
                        res.taken_id    = slot_ids[l][head_ptr[l]];
                        res.taken_level = LEVEL_W'(l);
                        head_ptr[l] = (head_ptr[l] + 1) % LEVEL_DEPTH;
                        level_fill[l]--;
                        break;
                    end
                end
            end
            empty = 1'b1;
            for (int l = 0; l < LEVELS; l++)
                if (level_fill[l] != 0)
                    empty = 1'b0;
            res.all_empty = empty;
            expected_results.push_back(res);
        endfunction

        // compare one output transfer with the oldest prediction
        function void check_result(out_item_t got);
            out_item_t want;

            if (expected_results.size() == 0)
            begin
                $error("result with nothing pending: %p", got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.taken_valid !== want.taken_valid)
            begin
                $error("taken_valid: expected %0d, actual %0d",
                       want.taken_valid, got.taken_valid);
                errors++;
            end
            if (got.taken_id !== want.taken_id)
            begin
                $error("taken_id: expected %0d, actual %0d", want.taken_id, got.taken_id);
                errors++;
            end
            if (got.taken_level !== want.taken_level)
            begin
                $error("taken_level: expected %0d, actual %0d",
                       want.taken_level, got.taken_level);
                errors++;
            end
            if (got.all_empty !== want.all_empty)
            begin
                $error("all_empty: expected %0d, actual %0d", want.all_empty, got.all_empty);
                errors++;
            end
            if (got.dropped_full !== want.dropped_full)
            begin
                $error("dropped_full: expected %0d, actual %0d",
                       want.dropped_full, got.dropped_full);
                errors++;
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    bit        steady = 1'b0;
    int        cycle_count = 0;

    ready_queue_scoreboard sb = new();

    multilevel_priority_fifo_core u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #10 clk = ~clk;

    // output side backpressure, none during the steady stretch
    always @(negedge clk)
    begin
        out_ready <= steady || ($urandom_range(99) >= 6);
    end

    // note input transfers before checking output transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.predict_result(in_data);
            if (out_valid && out_ready)
                sb.check_result(out_data);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // drive one operation, called at a falling edge, returns at a falling edge
    task automatic send_item(input opcode_t op, input logic [PID_W-1:0] pid,
                             input logic signed [PRIO_W-1:0] prio);
        if (!steady)
        begin
            while ($urandom_range(99) < 6)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid            <= 1'b1;
        in_data.opcode      <= op;
        in_data.process_id  <= pid;
        in_data.priority_req <= prio;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int        mode;
        int        enq_pct;
        int        hot_level;
        int        phase_left;
        opcode_t   op;
        logic [PID_W-1:0]         pid;
        logic signed [PRIO_W-1:0] prio;
        int        pick;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty dequeue, null id, priority extremes, every level
        send_item(OP_DEQUEUE, 8'd0, 8'sd0);
        send_item(OP_ENQUEUE, 8'd0, 8'sd0);
        send_item(OP_ENQUEUE, 8'd255, -8'sd128);
        send_item(OP_ENQUEUE, 8'd1, 8'sd127);
        send_item(OP_ENQUEUE, 8'd2, 8'sd4);
        send_item(OP_ENQUEUE, 8'd3, -8'sd1);
        send_item(OP_ENQUEUE, 8'd4, 8'sd3);
        send_item(OP_ENQUEUE, 8'd5, 8'sd2);
        send_item(OP_ENQUEUE, 8'd6, 8'sd1);
        send_item(OP_ENQUEUE, 8'd7, 8'sd0);
        send_item(OP_ENQUEUE, 8'd0, 8'sd3);
        send_item(OP_DEQUEUE, 8'd255, -8'sd1);
        send_item(OP_DEQUEUE, 8'd0, 8'sd0);
        send_item(OP_DEQUEUE, 8'd0, 8'sd0);
        send_item(OP_DEQUEUE, 8'd0, 8'sd0);
        send_item(OP_DEQUEUE, 8'd0, 8'sd0);
        send_item(OP_DEQUEUE, 8'd0, 8'sd0);
        send_item(OP_DEQUEUE, 8'd0, 8'sd0);
        send_item(OP_DEQUEUE, 8'd0, 8'sd0);
        send_item(OP_DEQUEUE, 8'd0, 8'sd0);

        // random phases: fill bursts reach full levels, drain bursts reach empty
        phase_left = 0;
        enq_pct    = 50;
        hot_level  = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 250 && n < 400);
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(60, 30);
                mode       = $urandom_range(2);
                enq_pct    = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
                hot_level  = $urandom_range(LEVELS - 1);
            end
            phase_left--;
            op   = ($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
            pid  = ($urandom_range(15) == 0) ? '0 : PID_W'($urandom_range(255, 1));
            pick = $urandom_range(99);
            if (pick < 50)
                prio = PRIO_W'(hot_level);
            else if (pick < 75)
                prio = PRIO_W'($urandom_range(LEVELS - 1));
            else
                prio = PRIO_W'($urandom);
            send_item(op, pid, prio);
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        // let every pending result arrive, then a short quiet window
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
src/mlpq_pkg.sv
src/mlpq_store.sv
src/mlpq_ctrl.sv
src/multilevel_priority_fifo_core.sv
test/multilevel_priority_fifo_core_test.sv
